FILE: rtl/cartridge_display_processor_assert.svh
// assertion macros used by the top rtl module
`ifndef CARTRIDGE_DISPLAY_PROCESSOR_ASSERT_SVH
`define CARTRIDGE_DISPLAY_PROCESSOR_ASSERT_SVH

`ifndef SYNTH
// property checked outside reset
`define CDP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked on every edge, reset included
`define CDP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDP_ASSERT(label, clk, rst, prop, msg)
`define CDP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: rtl/cdp_pkg.sv
package cdp_pkg;

  // sizes
  localparam int FETCHER_COUNT  = 8;
  localparam int ROM_DEPTH      = 2048;
  localparam int ROM_ADDR_W     = $clog2(ROM_DEPTH);
  localparam int FETCH_IDX_W    = $clog2(FETCHER_COUNT);
  localparam int COUNT_W        = 11;
  localparam int MUSIC_W        = 9;
  localparam int MUSIC_CHANNELS = 3;
  localparam int MUSIC_FIRST    = 5;

  // opcodes
  localparam logic [1:0] OP_ACCESS = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;

  // read port groups (port bits 5..3)
  localparam logic [2:0] RD_RANDOM    = 3'd0;
  localparam logic [2:0] RD_FETCH     = 3'd1;
  localparam logic [2:0] RD_FETCH_WIN = 3'd2;
  localparam logic [2:0] RD_FLAG      = 3'd7;

  // write port groups (port bits 5..3)
  localparam logic [2:0] WR_TOP      = 3'd0;
  localparam logic [2:0] WR_BOTTOM   = 3'd1;
  localparam logic [2:0] WR_COUNT_LO = 3'd2;
  localparam logic [2:0] WR_COUNT_HI = 3'd3;
  localparam logic [2:0] WR_RANDOM   = 3'd6;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
  localparam logic [MUSIC_W-1:0] MUSIC_RELOAD = '1;
  localparam logic [7:0]         RANDOM_SEED  = 8'h01;

  // note scaling: floor(d * 129 / 79) through a reciprocal multiply
  localparam int TUNE_MUL   = 129;
  localparam int TUNE_DIV   = 79;
  localparam int TUNE_SHIFT = 22;
  localparam int TUNE_RECIP = ((1 << TUNE_SHIFT) + TUNE_DIV - 1) / TUNE_DIV;

  // flag mix to audio level, index {f7, f6, f5}
  localparam logic [3:0] MIX_TABLE [8] = '{4'h0, 4'h6, 4'h5, 4'hb,
                                           4'h4, 4'ha, 4'h9, 4'hf};

  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [ROM_ADDR_W-1:0] addr;
    logic [7:0]            wdata;
  } rom_req_t;

  typedef struct packed {
    logic       use_rom;
    logic       rom_mask;
    logic [7:0] data;
    logic [3:0] level;
  } cdp_result_t;

  function automatic logic [MUSIC_W-1:0] tune(input logic [7:0] d);
    logic [15:0] x;
    logic [31:0] prod;
    x    = 16'(d) * 16'(TUNE_MUL);
    prod = 32'(x) * 32'(TUNE_RECIP);
    return prod[TUNE_SHIFT +: MUSIC_W];
  endfunction

endpackage

FILE: rtl/cdp_rom.sv
module cdp_rom (
  input  logic                      clk,
  input  cdp_pkg::rom_req_t         req,
  output logic [7:0]                rdata
);

  logic [7:0] mem [cdp_pkg::ROM_DEPTH];

  // single port: load writes, fetch reads, never both in one cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

FILE: rtl/cdp_core.sv
module cdp_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [1:0]                opcode,
  input  logic [6:0]                port_offset,
  input  logic [7:0]                bus_data,
  input  logic [10:0]               rom_address,
  output cdp_pkg::rom_req_t         rom_req,
  output cdp_pkg::cdp_result_t      result
);

  logic [cdp_pkg::COUNT_W-1:0] fetch_count [cdp_pkg::FETCHER_COUNT];
  logic [7:0]                  fetch_top [cdp_pkg::FETCHER_COUNT];
  logic [7:0]                  fetch_bottom [cdp_pkg::FETCHER_COUNT];
  logic [cdp_pkg::FETCHER_COUNT-1:0] window_flag;
  logic [cdp_pkg::MUSIC_CHANNELS-1:0] music_enable;
  logic [cdp_pkg::MUSIC_W-1:0] music_top [cdp_pkg::MUSIC_CHANNELS];
  logic [cdp_pkg::MUSIC_W-1:0] music_bottom [cdp_pkg::MUSIC_CHANNELS];
  logic [cdp_pkg::MUSIC_W-1:0] music_count [cdp_pkg::MUSIC_CHANNELS];
  logic [7:0]                  random_shift;
  logic [3:0]                  mixed_level;

  logic [cdp_pkg::COUNT_W-1:0] fetch_count_next [cdp_pkg::FETCHER_COUNT];
  logic [7:0]                  fetch_top_next [cdp_pkg::FETCHER_COUNT];
  logic [7:0]                  fetch_bottom_next [cdp_pkg::FETCHER_COUNT];
  logic [cdp_pkg::FETCHER_COUNT-1:0] window_flag_next;
  logic [cdp_pkg::MUSIC_CHANNELS-1:0] music_enable_next;
  logic [cdp_pkg::MUSIC_W-1:0] music_top_next [cdp_pkg::MUSIC_CHANNELS];
  logic [cdp_pkg::MUSIC_W-1:0] music_bottom_next [cdp_pkg::MUSIC_CHANNELS];
  logic [cdp_pkg::MUSIC_W-1:0] music_count_next [cdp_pkg::MUSIC_CHANNELS];
  logic [7:0]                  random_shift_next;
  logic [3:0]                  mixed_level_next;

  logic [cdp_pkg::FETCH_IDX_W-1:0] n;
  logic [2:0]                      grp;
  logic [cdp_pkg::COUNT_W-1:0]     cur_count;
  logic                            fetch_flag;
  logic [cdp_pkg::MUSIC_W-1:0]     tuned;
  logic                            feedback;

  assign n        = port_offset[2:0];
  assign grp      = port_offset[5:3];
  assign cur_count = fetch_count[n];
  assign tuned    = cdp_pkg::tune(bus_data);
  assign feedback = ~(random_shift[7] ^ random_shift[5] ^ random_shift[4] ^ random_shift[3]);

  // window flag as a fetch leaves it: set on top, then cleared on bottom
  always_comb begin
    fetch_flag = window_flag[n];
    if (cur_count[7:0] == fetch_top[n]) begin
      fetch_flag = 1'b1;
    end
    if (cur_count[7:0] == fetch_bottom[n]) begin
      fetch_flag = 1'b0;
    end
  end

  // next state and result for the accepted request
  always_comb begin
    fetch_count_next  = fetch_count;
    fetch_top_next    = fetch_top;
    fetch_bottom_next = fetch_bottom;
    window_flag_next  = window_flag;
    music_enable_next = music_enable;
    music_top_next    = music_top;
    music_bottom_next = music_bottom;
    music_count_next  = music_count;
    random_shift_next = random_shift;
    mixed_level_next  = mixed_level;
    rom_req           = '0;
    result            = '0;

    if (accept) begin
      case (opcode)
        cdp_pkg::OP_ACCESS: begin
          if (!port_offset[6]) begin
            case (grp)
              cdp_pkg::RD_RANDOM: begin
                if (port_offset[2]) begin
                  result.data = {4'h0, mixed_level};
                end else begin
                  random_shift_next = {random_shift[6:0], feedback};
                  result.data       = {random_shift[6:0], feedback};
                end
              end
              cdp_pkg::RD_FETCH, cdp_pkg::RD_FETCH_WIN: begin
                window_flag_next[n] = fetch_flag;
                fetch_count_next[n] = cur_count - 1'b1;
                rom_req.re          = 1'b1;
                rom_req.addr        = cdp_pkg::COUNT_MAX - cur_count;
                result.use_rom      = 1'b1;
                result.rom_mask     = (grp == cdp_pkg::RD_FETCH) ? 1'b1 : fetch_flag;
              end
              cdp_pkg::RD_FLAG: begin
                result.data = window_flag[n] ? 8'hff : 8'h00;
              end
              default: begin
              end
            endcase
          end else begin
            case (grp)
              cdp_pkg::WR_TOP: begin
                fetch_top_next[n] = bus_data;
                for (int k = 0; k < cdp_pkg::MUSIC_CHANNELS; k++) begin
                  if (n == cdp_pkg::FETCH_IDX_W'(cdp_pkg::MUSIC_FIRST + k)) begin
                    music_top_next[k] = tuned;
                  end
                end
              end
              cdp_pkg::WR_BOTTOM: begin
                fetch_bottom_next[n] = bus_data;
                for (int k = 0; k < cdp_pkg::MUSIC_CHANNELS; k++) begin
                  if (n == cdp_pkg::FETCH_IDX_W'(cdp_pkg::MUSIC_FIRST + k)) begin
                    music_bottom_next[k] = tuned;
                  end
                end
              end
              cdp_pkg::WR_COUNT_LO: begin
                fetch_count_next[n] = {cur_count[10:8], bus_data};
                for (int k = 0; k < cdp_pkg::MUSIC_CHANNELS; k++) begin
                  if (n == cdp_pkg::FETCH_IDX_W'(cdp_pkg::MUSIC_FIRST + k)) begin
                    music_count_next[k] = tuned;
                  end
                end
              end
              cdp_pkg::WR_COUNT_HI: begin
                fetch_count_next[n] = {bus_data[2:0], cur_count[7:0]};
                window_flag_next[n] = 1'b0;
                for (int k = 0; k < cdp_pkg::MUSIC_CHANNELS; k++) begin
                  if (n == cdp_pkg::FETCH_IDX_W'(cdp_pkg::MUSIC_FIRST + k)) begin
                    music_enable_next[k] = bus_data[4];
                  end
                end
              end
              cdp_pkg::WR_RANDOM: begin
                random_shift_next = cdp_pkg::RANDOM_SEED;
              end
              default: begin
              end
            endcase
          end
        end
        cdp_pkg::OP_TICK: begin
          // each enabled channel steps its square-wave counter
          for (int k = 0; k < cdp_pkg::MUSIC_CHANNELS; k++) begin
            if (music_enable[k]) begin
              if (music_count[k] == music_bottom[k]) begin
                window_flag_next[cdp_pkg::MUSIC_FIRST + k] = 1'b0;
                music_count_next[k] = music_count[k] - 1'b1;
              end else if (music_count[k] == cdp_pkg::MUSIC_RELOAD) begin
                window_flag_next[cdp_pkg::MUSIC_FIRST + k] = 1'b1;
                music_count_next[k] = music_top[k];
              end else begin
                music_count_next[k] = music_count[k] - 1'b1;
              end
            end
          end
          mixed_level_next = cdp_pkg::MIX_TABLE[
            window_flag_next[cdp_pkg::MUSIC_FIRST +: cdp_pkg::MUSIC_CHANNELS]];
        end
        cdp_pkg::OP_LOAD: begin
          rom_req.we    = 1'b1;
          rom_req.addr  = rom_address;
          rom_req.wdata = bus_data;
        end
        default: begin
        end
      endcase
    end

    result.level = mixed_level_next;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cdp_pkg::FETCHER_COUNT; i++) begin
        fetch_count[i]  <= '0;
        fetch_top[i]    <= '0;
        fetch_bottom[i] <= '0;
      end
      for (int k = 0; k < cdp_pkg::MUSIC_CHANNELS; k++) begin
        music_top[k]    <= '0;
        music_bottom[k] <= '0;
        music_count[k]  <= '0;
      end
      window_flag  <= '0;
      music_enable <= '0;
      random_shift <= cdp_pkg::RANDOM_SEED;
      mixed_level  <= '0;
    end else begin
      fetch_count  <= fetch_count_next;
      fetch_top    <= fetch_top_next;
      fetch_bottom <= fetch_bottom_next;
      music_top    <= music_top_next;
      music_bottom <= music_bottom_next;
      music_count  <= music_count_next;
      window_flag  <= window_flag_next;
      music_enable <= music_enable_next;
      random_shift <= random_shift_next;
      mixed_level  <= mixed_level_next;
    end
  end

endmodule

FILE: rtl/cartridge_display_processor.sv
// Cartridge display processor behind a 128-port bus window, with an 8-fetcher
// data unit, a random byte generator, three music channels and a 2K graphics
// memory filled by load requests. While in_ready is high one request is taken
// every clock; each gives one result through the registered read of the
// single-port graphics memory and then the output register. That memory port,
// one access per cycle, sets the rate of one request per clock. in_ready drops
// only while both the read stage and the output register hold results that
// the consumer has not yet taken. There is no clearing pass.
`include "cartridge_display_processor_assert.svh"

module cartridge_display_processor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [6:0]  port_offset,
  input  logic [7:0]  bus_data,
  input  logic [10:0] rom_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic [3:0]  audio_level
);

  logic                 in_accept;
  logic                 out_free;
  logic                 s1_move;
  logic                 s1_valid;
  cdp_pkg::cdp_result_t s1_result;
  cdp_pkg::cdp_result_t core_result;
  cdp_pkg::rom_req_t    rom_req;
  logic [7:0]           rom_rdata;

  assign out_free  = !out_valid || out_ready;
  assign s1_move   = s1_valid && out_free;
  assign in_ready  = !s1_valid || out_free;
  assign in_accept = in_valid && in_ready;

  // fetcher, music and random state
  cdp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .opcode      (opcode),
    .port_offset (port_offset),
    .bus_data    (bus_data),
    .rom_address (rom_address),
    .rom_req     (rom_req),
    .result      (core_result)
  );

  // graphics memory
  cdp_rom u_rom (
    .clk   (clk),
    .req   (rom_req),
    .rdata (rom_rdata)
  );

  // read stage: waits for the memory data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_result <= core_result;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      if (s1_result.use_rom) begin
        read_data <= s1_result.rom_mask ? rom_rdata : 8'h00;
      end else begin
        read_data <= s1_result.data;
      end
      audio_level <= s1_result.level;
    end
  end

  `CDP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !s1_valid && !out_valid, "not empty after reset")
  `CDP_ASSERT(a_accept_fills, clk, rst, in_accept |=> s1_valid, "accepted request lost")
  `CDP_ASSERT(a_stall_hold, clk, rst, s1_valid && !out_free |=> $stable(rom_rdata), "stall lost data")

endmodule
